// File: rtl/core/bvm_pkg.sv
// Package for the battery voltage monitor: payload structs, codes, constants
// and the charge-percentage function. No dependencies.
package bvm_pkg;

    localparam int HIST_DEPTH = 16;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int HCNT_W     = $clog2(HIST_DEPTH + 1);
    localparam int MV_W       = 13;
    localparam int SUM_W      = MV_W + HIST_AW + 1;

    localparam logic [MV_W-1:0] REJECT_MV = 13'd2000;
    localparam logic [MV_W-1:0] MIN_FLOOR_MV = 13'd3000;

    localparam logic [1:0] CFG_CHARGING = 2'd0;
    localparam logic [1:0] CFG_FULL     = 2'd1;
    localparam logic [1:0] CFG_LOW      = 2'd2;
    localparam logic [1:0] CFG_CRITICAL = 2'd3;

    localparam logic [1:0] SRC_UNKNOWN  = 2'd0;
    localparam logic [1:0] SRC_BATTERY  = 2'd1;
    localparam logic [1:0] SRC_CHARGING = 2'd2;
    localparam logic [1:0] SRC_FULL     = 2'd3;

    localparam logic [2:0] ST_UNKNOWN     = 3'd0;
    localparam logic [2:0] ST_DISCHARGING = 3'd1;
    localparam logic [2:0] ST_CHARGING    = 3'd2;
    localparam logic [2:0] ST_FULL        = 3'd3;
    localparam logic [2:0] ST_LOW         = 3'd4;
    localparam logic [2:0] ST_CRITICAL    = 3'd5;

    localparam logic [1:0] HEALTH_GOOD     = 2'd0;
    localparam logic [1:0] HEALTH_FAIR     = 2'd1;
    localparam logic [1:0] HEALTH_POOR     = 2'd2;
    localparam logic [1:0] HEALTH_DEGRADED = 2'd3;

    typedef struct packed {
        logic [12:0] voltage_mv;
        logic [31:0] time_ms;
    } in_beat_t;

    typedef struct packed {
        logic        accepted;
        logic [6:0]  percent;
        logic [1:0]  source;
        logic [2:0]  charge_state;
        logic        low_alert;
        logic        critical_alert;
        logic [12:0] min_seen_mv;
        logic [12:0] max_seen_mv;
        logic [1:0]  health_grade;
        logic [31:0] time_low_ms;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic accum;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic good;
        logic last_pair;
    } stat_t;

    // Tens of a small value by a reciprocal multiply (exact below 1000).
    function automatic logic [6:0] div10(input logic [9:0] x);
        logic [19:0] p;
        begin
            p = 20'(x) * 20'd205;
            div10 = 7'(p >> 11);
        end
    endfunction

    // Piecewise-linear LiPo state of charge.
    function automatic logic [6:0] soc_percent(input logic [12:0] v);
        logic [9:0] d;
        logic [11:0] m;
        begin
            d = '0;
            m = '0;
            if (v >= 13'd4200) begin
                soc_percent = 7'd100;
            end else if (v >= 13'd3600) begin
                d = 10'(v - 13'd3600);
                soc_percent = 7'd40 + div10(d);
            end else if (v >= 13'd3500) begin
                // Hundredths of fifteen times the offset, by a reciprocal multiply.
                d = 10'(v - 13'd3500);
                m = 12'(d) * 12'd15;
                soc_percent = 7'd25 + 7'((22'(m) * 22'd1311) >> 17);
            end else if (v >= 13'd3400) begin
                d = 10'(v - 13'd3400);
                soc_percent = 7'd15 + div10(d);
            end else if (v >= 13'd3300) begin
                d = 10'(v - 13'd3300);
                soc_percent = 7'd5 + div10(d);
            end else if (v >= 13'd3200) begin
                d = 10'(v - 13'd3200);
                soc_percent = div10({1'b0, d[9:1]});
            end else begin
                soc_percent = 7'd0;
            end
        end
    endfunction

endpackage

// File: rtl/core/bvm_ctrl.sv
// Controller state machine for the battery voltage monitor.
// Depends on bvm_pkg.
module bvm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  bvm_pkg::stat_t stat,
    output bvm_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SUM   = 4'b0010,
        S_FIN   = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Ready only when idle; result waits in S_OUT.
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                if (!stat.good || stat.last_pair) begin
                    state_next = S_FIN;
                end else begin
                    cmd.accum = 1'b1;
                end
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/bvm_datapath.sv
// Datapath of the battery voltage monitor: history ring, trend sums,
// classification and tracking state. Depends on bvm_pkg.
module bvm_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  bvm_pkg::in_beat_t   s_data,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    input  bvm_pkg::cmd_t       cmd,
    output bvm_pkg::stat_t      stat,
    output bvm_pkg::out_beat_t  m_data
);

    localparam int AW = bvm_pkg::HIST_AW;
    localparam int CW = bvm_pkg::HCNT_W;
    localparam int SW = bvm_pkg::SUM_W;

    logic [12:0] charging_reg, full_reg, low_reg, critical_reg;
    logic [12:0] hist_mem [bvm_pkg::HIST_DEPTH];
    logic [AW-1:0] wr_idx_reg;
    logic          full_hist_reg;
    logic [12:0]   min_reg, max_reg;
    logic          was_low_reg, low_sent_reg, crit_sent_reg;
    logic [31:0]   low_start_reg, low_total_reg;
    logic [1:0]    src_reg;
    logic [2:0]    st_reg;
    logic [6:0]    pct_reg;

    logic [12:0]   v_reg;
    logic [31:0]   t_reg;
    logic          good_reg;
    logic [CW-2:0] half_reg;
    logic [CW-2:0] i_reg;
    logic [SW-1:0] sn_reg, so_reg;
    logic [12:0]   rd_n_reg, rd_o_reg;
    logic          la_reg, ca_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charging_reg <= 13'd4300;
            full_reg     <= 13'd4150;
            low_reg      <= 13'd3500;
            critical_reg <= 13'd3300;
        end else if (cfg_valid) begin
            case (cfg_index)
                bvm_pkg::CFG_CHARGING: charging_reg <= cfg_data;
                bvm_pkg::CFG_FULL:     full_reg     <= cfg_data;
                bvm_pkg::CFG_LOW:      low_reg      <= cfg_data;
                bvm_pkg::CFG_CRITICAL: critical_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Count after the new sample is written, and the half length.
    logic [AW-1:0] wr_idx_next;
    logic          full_next;
    logic [CW-1:0] count_next;
    assign wr_idx_next = wr_idx_reg + 1'b1;
    assign full_next   = full_hist_reg || (wr_idx_reg == AW'(bvm_pkg::HIST_DEPTH - 1));
    assign count_next  = full_next ? CW'(bvm_pkg::HIST_DEPTH) : CW'(wr_idx_next);

    // Read addresses walk back from the newest entry.
    logic [AW-1:0] n_addr, o_addr;
    assign n_addr = wr_idx_reg - AW'(1) - AW'(i_reg);
    assign o_addr = wr_idx_reg - AW'(1) - AW'(half_reg) - AW'(i_reg);

    // History ring: one write per accepted sample, two registered reads per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.load && s_data.voltage_mv >= bvm_pkg::REJECT_MV) begin
            hist_mem[wr_idx_reg] <= s_data.voltage_mv;
        end
        rd_n_reg <= hist_mem[n_addr];
        rd_o_reg <= hist_mem[o_addr];
    end

    assign stat.good      = good_reg;
    assign stat.last_pair = (half_reg == '0) || (i_reg == half_reg);

    // Trend walk: pointer and running sums, with the read data registered behind the pointer.
    logic rd_vld_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg    <= s_data.voltage_mv;
            t_reg    <= s_data.time_ms;
            i_reg    <= '0;
            half_reg <= (count_next < CW'(4)) ? '0 : count_next[CW-1:1];
            sn_reg   <= '0;
            so_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (cmd.accum) begin
                i_reg <= i_reg + 1'b1;
            end
            rd_vld_reg <= cmd.accum;
            if (rd_vld_reg) begin
                sn_reg <= sn_reg + SW'(rd_n_reg);
                so_reg <= so_reg + SW'(rd_o_reg);
            end
        end
    end

    // Classification of the accepted sample.
    logic signed [SW:0] diff;
    logic               flat, rising, low_now;
    logic [1:0]         src;
    logic [2:0]         st;
    assign diff   = $signed({1'b0, sn_reg}) - $signed({1'b0, so_reg});
    assign flat   = diff <= $signed((SW+1)'({half_reg, 1'b0}));
    assign rising = diff >  $signed((SW+1)'({half_reg, 3'b000}));
    assign low_now = (v_reg <= low_reg) && (src_reg == bvm_pkg::SRC_BATTERY);

    always_comb begin
        if (v_reg > charging_reg) begin
            src = (v_reg >= full_reg && flat) ? bvm_pkg::SRC_FULL : bvm_pkg::SRC_CHARGING;
        end else if (v_reg >= full_reg && flat) begin
            src = bvm_pkg::SRC_FULL;
        end else if (rising) begin
            src = bvm_pkg::SRC_CHARGING;
        end else begin
            src = bvm_pkg::SRC_BATTERY;
        end
        if (src == bvm_pkg::SRC_FULL)          st = bvm_pkg::ST_FULL;
        else if (src == bvm_pkg::SRC_CHARGING) st = bvm_pkg::ST_CHARGING;
        else if (v_reg <= critical_reg)        st = bvm_pkg::ST_CRITICAL;
        else if (v_reg <= low_reg)             st = bvm_pkg::ST_LOW;
        else                                   st = bvm_pkg::ST_DISCHARGING;
    end

    // Stored status, updated at load (ring pointer, percentage, acceptance) and finish (extremes and the rest).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg    <= '0;
            full_hist_reg <= 1'b0;
            min_reg       <= 13'h1FFF;
            max_reg       <= '0;
            was_low_reg   <= 1'b0;
            low_start_reg <= '0;
            low_total_reg <= '0;
            low_sent_reg  <= 1'b0;
            crit_sent_reg <= 1'b0;
            src_reg       <= bvm_pkg::SRC_UNKNOWN;
            st_reg        <= bvm_pkg::ST_UNKNOWN;
            pct_reg       <= '0;
            good_reg      <= 1'b0;
            la_reg        <= 1'b0;
            ca_reg        <= 1'b0;
        end else begin
            if (cmd.load) begin
                good_reg <= s_data.voltage_mv >= bvm_pkg::REJECT_MV;
                la_reg   <= 1'b0;
                ca_reg   <= 1'b0;
                if (s_data.voltage_mv >= bvm_pkg::REJECT_MV) begin
                    wr_idx_reg    <= wr_idx_next;
                    full_hist_reg <= full_next;
                    pct_reg       <= bvm_pkg::soc_percent(s_data.voltage_mv);
                end
            end
            if (cmd.finish && good_reg) begin
                if (v_reg > bvm_pkg::MIN_FLOOR_MV && v_reg < min_reg) min_reg <= v_reg;
                if (v_reg > max_reg) max_reg <= v_reg;
                if (low_now && !was_low_reg) begin
                    low_start_reg <= t_reg;
                    was_low_reg   <= 1'b1;
                end
                if (!low_now && was_low_reg) begin
                    low_total_reg <= low_total_reg + (t_reg - low_start_reg);
                    was_low_reg   <= 1'b0;
                end
                src_reg <= src;
                st_reg  <= st;
                la_reg  <= (st == bvm_pkg::ST_LOW) && !low_sent_reg;
                ca_reg  <= (st == bvm_pkg::ST_CRITICAL) && !crit_sent_reg;
                low_sent_reg  <= (st == bvm_pkg::ST_LOW);
                crit_sent_reg <= (st == bvm_pkg::ST_CRITICAL);
            end
        end
    end

    // Result beat from the stored status.
    always_comb begin
        m_data.accepted       = good_reg;
        m_data.percent        = pct_reg;
        m_data.source         = src_reg;
        m_data.charge_state   = st_reg;
        m_data.low_alert      = la_reg;
        m_data.critical_alert = ca_reg;
        m_data.min_seen_mv    = min_reg;
        m_data.max_seen_mv    = max_reg;
        if (min_reg >= 13'd3600)      m_data.health_grade = bvm_pkg::HEALTH_GOOD;
        else if (min_reg >= 13'd3400) m_data.health_grade = bvm_pkg::HEALTH_FAIR;
        else if (min_reg >= 13'd3200) m_data.health_grade = bvm_pkg::HEALTH_POOR;
        else                          m_data.health_grade = bvm_pkg::HEALTH_DEGRADED;
        m_data.time_low_ms = low_total_reg + (was_low_reg ? (t_reg - low_start_reg) : 32'd0);
    end

endmodule

// File: rtl/core/battery_voltage_monitor_top.sv
// Top level of the battery voltage monitor: controller plus datapath.
// Depends on bvm_pkg, bvm_ctrl and bvm_datapath.
//
// One sample beat in gives one result beat out. An accepted sample with N
// history entries (N at least four, counting itself) goes through the trend
// walk, which reads one newer and one older history entry per cycle from the
// two-port ring, pairing each entry of the newer half of the history with the
// entry half the history length older; with fewer than four entries, and for
// a rejected sample, no pairs are summed. The block works on one sample at a
// time, holds the result until it is taken and is ready for the next sample
// in the cycle after that. Configuration writes are always ready and are meant
// for idle periods.
module battery_voltage_monitor_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bvm_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bvm_pkg::out_beat_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data
);

    bvm_pkg::cmd_t  cmd;
    bvm_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    bvm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bvm_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule
